### hdl/frame_truncate_word_repacker_assert.svh
// Assertion macros used by the checker file of this block.
// Every macro samples on the rising edge of clk and is switched off while rst_n is low.
`ifndef FRAME_TRUNCATE_WORD_REPACKER_ASSERT_SVH
`define FRAME_TRUNCATE_WORD_REPACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTWR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame_truncate_word_repacker: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FTWR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame_truncate_word_repacker: next-cycle check failed");

`endif

### hdl/ftwr_pkg.sv
`default_nettype none

package ftwr_pkg;

    localparam int FRAME_BITS_DEF = 128;
    localparam int KEPT_BITS_DEF  = 126;
    localparam int WORD_BITS_DEF  = 32;

    localparam int BYTE_BITS = 8;
    localparam int OUT_BITS  = 32;

    // Kept bits of one byte, packed down to bit 0, with their count (0..8).
    typedef struct packed {
        logic       valid;
        logic [7:0] bits;
        logic [3:0] count;
    } kept_t;

endpackage

`default_nettype wire

### hdl/ftwr_frame_stage.sv
`default_nettype none

module ftwr_frame_stage #(
    parameter int FRAME_BITS = ftwr_pkg::FRAME_BITS_DEF,
    parameter int KEPT_BITS  = ftwr_pkg::KEPT_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         drop_at_tail,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   in_byte,
    input  wire logic         out_ready,
    output ftwr_pkg::kept_t   out_kept
);
    import ftwr_pkg::*;

    localparam int FRAME_BYTES = FRAME_BITS / BYTE_BITS;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int BASE_W      = POS_W + 3;
    localparam int DROP_BITS   = FRAME_BITS - KEPT_BITS;

    localparam logic [BASE_W:0] DROP_L  = (BASE_W + 1)'(DROP_BITS);
    localparam logic [BASE_W:0] KEPT_L  = (BASE_W + 1)'(KEPT_BITS);
    localparam logic [BASE_W:0] BYTE_L  = (BASE_W + 1)'(BYTE_BITS);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    kept_t            kept_reg;
    kept_t            kept_next;
    logic [BASE_W:0]  base;
    logic [3:0]       low_drop;
    logic [3:0]       head_keep;
    logic [BASE_W:0]  tail_gap;
    logic [BASE_W:0]  head_gap;
    logic             take;

    assign in_ready = !kept_reg.valid || out_ready;
    assign take     = in_valid && in_ready;
    assign out_kept = kept_reg;

    // First frame bit carried by the incoming byte.
    assign base     = {1'b0, pos_reg, 3'b000};
    assign tail_gap = DROP_L - base;
    assign head_gap = KEPT_L - base;

    always_comb
    begin
        priority if (base >= DROP_L)
        begin
            low_drop = 4'd0;
        end
        else if (tail_gap >= BYTE_L)
        begin
            low_drop = 4'd8;
        end
        else
        begin
            low_drop = tail_gap[3:0];
        end

        priority if (base >= KEPT_L)
        begin
            head_keep = 4'd0;
        end
        else if (head_gap >= BYTE_L)
        begin
            head_keep = 4'd8;
        end
        else
        begin
            head_keep = head_gap[3:0];
        end
    end

    always_comb
    begin
        kept_next = kept_reg;
        pos_next  = pos_reg;
        if (take)
        begin
            kept_next.valid = 1'b1;
            if (drop_at_tail)
            begin
                kept_next.bits  = in_byte >> low_drop;
                kept_next.count = 4'd8 - low_drop;
            end
            else
            begin
                kept_next.bits  = in_byte & ~(8'hFF << head_keep);
                kept_next.count = head_keep;
            end
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
        end
        else if (out_ready)
        begin
            kept_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            kept_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            kept_reg <= kept_next;
        end
    end

endmodule

`default_nettype wire

### hdl/ftwr_pack_stage.sv
`default_nettype none

module ftwr_pack_stage #(
    parameter int WORD_BITS = ftwr_pkg::WORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ftwr_pkg::kept_t               in_kept,
    output logic                               in_ready,
    output logic                               word_valid,
    input  wire logic                          word_ready,
    output logic [ftwr_pkg::OUT_BITS-1:0]      word_data
);
    import ftwr_pkg::*;

    localparam int ACC_W = WORD_BITS + 7;
    localparam int CNT_W = $clog2(WORD_BITS);
    localparam int SUM_W = $clog2(WORD_BITS + 8);
    localparam logic [SUM_W-1:0] WORD_L = SUM_W'(WORD_BITS);

    logic [WORD_BITS-2:0]  pend_reg;
    logic [WORD_BITS-2:0]  pend_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic [OUT_BITS-1:0]   word_reg;
    logic [OUT_BITS-1:0]   word_next;
    logic [ACC_W-1:0]      merged;
    logic [SUM_W-1:0]      total;
    logic [WORD_BITS-1:0]  full_word;
    logic                  free;

    assign free       = !valid_reg || word_ready;
    assign in_ready   = free;
    assign word_valid = valid_reg;
    assign word_data  = word_reg;

    // New bits land directly above the pending ones.
    assign merged    = ACC_W'(pend_reg) | (ACC_W'(in_kept.bits) << cnt_reg);
    assign total     = SUM_W'(cnt_reg) + SUM_W'(in_kept.count);
    assign full_word = merged[WORD_BITS-1:0];

    always_comb
    begin
        pend_next  = pend_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        word_next  = word_reg;
        if (free)
        begin
            valid_next = 1'b0;
            if (in_kept.valid)
            begin
                if (total >= WORD_L)
                begin
                    valid_next = 1'b1;
                    word_next  = OUT_BITS'(full_word);
                    pend_next  = (WORD_BITS - 1)'(merged >> WORD_BITS);
                    cnt_next   = CNT_W'(total - WORD_L);
                end
                else
                begin
                    pend_next = merged[WORD_BITS-2:0];
                    cnt_next  = total[CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

`default_nettype wire

### hdl/frame_truncate_word_repacker.sv
// Channel   | Direction | Ports                                   | Payload
// ----------+-----------+-----------------------------------------+------------------------------
// s         | in        | s_tvalid, s_tready, s_tdata[7:0]        | data_byte
// m         | out       | m_tvalid, m_tready, m_tdata[31:0]       | packed_word
// cfg       | in        | cfg_valid, cfg_ready, cfg_data[0:0]     | drop_at_tail
//
// Every byte passes through two register stages: the frame stage strips the dropped bits
// and packs the kept ones down, and the pack stage appends them to the pending bits and
// loads a finished word into the output register. One byte is taken every clock cycle
// while m is not stalled. A byte accepted on s is registered in the frame stage, and the
// word it completes, if any, is then registered in the pack stage and offered on m.
// Reset (rst_n low, asynchronous) empties both stages, clears the pending bits, starts a
// new frame and sets drop_at_tail to 1. The configuration port is always ready.
// A stall on m holds the output word and backs up into s_tready through the frame stage.
`default_nettype none

module frame_truncate_word_repacker #(
    parameter int FRAME_BITS = ftwr_pkg::FRAME_BITS_DEF,
    parameter int KEPT_BITS  = ftwr_pkg::KEPT_BITS_DEF,
    parameter int WORD_BITS  = ftwr_pkg::WORD_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Input byte stream.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [7:0] data_byte
    // Output word stream.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [ftwr_pkg::OUT_BITS-1:0]       m_tdata,   // [31:0] packed_word
    // Configuration write channel.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [0:0]                     cfg_data   // [0] drop_at_tail
);
    import ftwr_pkg::*;

    logic  drop_at_tail_reg;
    logic  drop_at_tail_next;
    kept_t kept;
    logic  pack_ready;

    // The register may be written at any cycle; the block only relies on it being
    // stable while bytes are in flight.
    assign cfg_ready         = 1'b1;
    assign drop_at_tail_next = (cfg_valid && cfg_ready) ? cfg_data[0] : drop_at_tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_at_tail_reg <= 1'b1;
        end
        else
        begin
            drop_at_tail_reg <= drop_at_tail_next;
        end
    end

    // Frame stage: tracks the byte position inside the frame and removes the dropped
    // bits, leaving the kept bits of the byte packed at bit 0 with their count.
    ftwr_frame_stage #(
        .FRAME_BITS (FRAME_BITS),
        .KEPT_BITS  (KEPT_BITS)
    ) u_frame_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .drop_at_tail (drop_at_tail_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_byte      (s_tdata),
        .out_ready    (pack_ready),
        .out_kept     (kept)
    );

    // Pack stage: appends kept bits to the pending accumulator and emits a word
    // whenever WORD_BITS bits are gathered; leftovers stay for the next byte.
    ftwr_pack_stage #(
        .WORD_BITS (WORD_BITS)
    ) u_pack_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_kept    (kept),
        .in_ready   (pack_ready),
        .word_valid (m_tvalid),
        .word_ready (m_tready),
        .word_data  (m_tdata)
    );

endmodule

`default_nettype wire

### hdl/ftwr_checker.sv
`default_nettype none

`include "frame_truncate_word_repacker_assert.svh"

module ftwr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // A stalled output word stays offered and unchanged.
    `FTWR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The input side only backs up when the output side is stalled.
    `FTWR_ASSERT_SAME(a_backpressure, !s_tready, m_tvalid && !m_tready)

    // When reset is released, nothing is offered and the input side is ready.
    `FTWR_ASSERT_SAME(a_reset_empty, $rose(rst_n), !m_tvalid && s_tready)

    // The configuration channel never stalls.
    `FTWR_ASSERT_NEXT(a_cfg_ready, cfg_valid, cfg_ready && $past(cfg_ready))

endmodule

bind frame_truncate_word_repacker ftwr_checker u_ftwr_checker (.*);

`default_nettype wire
